/* design/acd_pkg.sv */
package acd_pkg;

    localparam int LOAD_BITS_DEFAULT  = 16;
    localparam int TOTAL_BITS_DEFAULT = 32;

    localparam int ADDR_BITS = 4;
    localparam int DATA_BITS = 32;

    typedef logic [1:0] t_core;
    typedef logic [1:0] t_reg_idx;
    typedef logic [1:0] t_cost;

    localparam t_core CORE0 = 2'd0;
    localparam t_core CORE1 = 2'd1;
    localparam t_core CORE2 = 2'd2;

    localparam t_reg_idx REG_MODE  = 2'd0;
    localparam t_reg_idx REG_HOME0 = 2'd1;
    localparam t_reg_idx REG_HOME1 = 2'd2;
    localparam t_reg_idx REG_HOME2 = 2'd3;

    localparam logic MODE_GREEDY = 1'b0;
    localparam logic MODE_RR     = 1'b1;

    localparam logic CMD_DISPATCH = 1'b0;
    localparam logic CMD_CLEAR    = 1'b1;

    localparam t_cost COST_NONE = 2'd0;
    localparam t_cost COST_HOME = 2'd1;
    localparam t_cost COST_AWAY = 2'd2;

    localparam logic [7:0] HOME0_RESET = 8'd72;
    localparam logic [7:0] HOME1_RESET = 8'd77;
    localparam logic [7:0] HOME2_RESET = 8'd76;

    typedef struct packed {
        logic            mode;
        logic [2:0][7:0] home_type;
    } t_cfg;

    typedef struct packed {
        logic       cmd;
        logic [7:0] task_type;
        logic       last;
    } t_item;

    typedef struct packed {
        logic        placed;
        t_core       chosen_core;
        t_cost       task_cost;
        logic        batch_done;
        logic [15:0] batch_time;
        logic [31:0] run_total;
    } t_result;

    function automatic t_core next_core(input t_core c);
        return (c >= CORE2) ? CORE0 : t_core'(c + 2'd1);
    endfunction

endpackage

/* design/acd_engine.sv */
module acd_engine #(
    parameter int LOAD_BITS  = acd_pkg::LOAD_BITS_DEFAULT,
    parameter int TOTAL_BITS = acd_pkg::TOTAL_BITS_DEFAULT
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_fire,
    input  acd_pkg::t_item  i_item,
    input  acd_pkg::t_cfg   i_cfg,
    output acd_pkg::t_result o_result
);

    localparam int SUM_BITS = ((LOAD_BITS > TOTAL_BITS) ? LOAD_BITS : TOTAL_BITS) + 1;

    logic [LOAD_BITS-1:0]  r_load [3];
    logic [LOAD_BITS-1:0]  n_load [3];
    logic [TOTAL_BITS-1:0] r_total, n_total;
    acd_pkg::t_core        r_rot, n_rot;

    logic [2:0]            match;
    logic                  found;
    acd_pkg::t_core        home, nxt1, nxt2, rr_core, core;
    logic                  placed;
    logic                  core_match;
    acd_pkg::t_cost        cost;
    logic [LOAD_BITS:0]    lh, l1, l2;
    logic [LOAD_BITS:0]    load_sum [3];
    logic [LOAD_BITS-1:0]  upd_load [3];
    logic [LOAD_BITS-1:0]  max01, max_load;
    logic [SUM_BITS-1:0]   total_sum;
    logic [TOTAL_BITS-1:0] total_acc;
    logic [LOAD_BITS+15:0] btime_ext;
    logic [TOTAL_BITS+31:0] total_ext;

    function automatic logic [LOAD_BITS-1:0] pick(input logic [LOAD_BITS-1:0] a,
                                                  input logic [LOAD_BITS-1:0] b,
                                                  input logic [LOAD_BITS-1:0] c,
                                                  input acd_pkg::t_core k);
        logic [LOAD_BITS-1:0] v;
        case (k)
            acd_pkg::CORE1: v = b;
            acd_pkg::CORE2: v = c;
            default:        v = a;
        endcase
        return v;
    endfunction

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            match[i] = (i_cfg.home_type[i] == i_item.task_type);
        end
        found = |match;
        home  = match[0] ? acd_pkg::CORE0 : (match[1] ? acd_pkg::CORE1 : acd_pkg::CORE2);
        nxt1  = acd_pkg::next_core(home);
        nxt2  = acd_pkg::next_core(nxt1);

        lh = {1'b0, pick(r_load[0], r_load[1], r_load[2], home)} + (LOAD_BITS+1)'(1);
        l1 = {1'b0, pick(r_load[0], r_load[1], r_load[2], nxt1)} + (LOAD_BITS+1)'(2);
        l2 = {1'b0, pick(r_load[0], r_load[1], r_load[2], nxt2)} + (LOAD_BITS+1)'(2);

        // rotation never holds 3, guard anyway
        rr_core = (r_rot > acd_pkg::CORE2) ? acd_pkg::CORE0 : r_rot;

        if (i_cfg.mode == acd_pkg::MODE_RR) begin
            core   = rr_core;
            placed = 1'b1;
        end else if (found) begin
            placed = 1'b1;
            if (lh <= l1 && lh <= l2) begin
                core = home;
            end else if (l1 <= l2) begin
                core = nxt1;
            end else begin
                core = nxt2;
            end
        end else begin
            core   = acd_pkg::CORE0;
            placed = 1'b0;
        end

        case (core)
            acd_pkg::CORE1: core_match = match[1];
            acd_pkg::CORE2: core_match = match[2];
            default:        core_match = match[0];
        endcase
        cost = !placed ? acd_pkg::COST_NONE :
               (core_match ? acd_pkg::COST_HOME : acd_pkg::COST_AWAY);

        // saturating load update on the chosen core
        for (int i = 0; i < 3; i++) begin
            load_sum[i] = {1'b0, r_load[i]} + {{(LOAD_BITS-1){1'b0}}, cost};
            if (placed && core == 2'(i)) begin
                upd_load[i] = load_sum[i][LOAD_BITS] ? '1 : load_sum[i][LOAD_BITS-1:0];
            end else begin
                upd_load[i] = r_load[i];
            end
        end

        max01    = (upd_load[1] > upd_load[0]) ? upd_load[1] : upd_load[0];
        max_load = (upd_load[2] > max01) ? upd_load[2] : max01;

        total_sum = {{(SUM_BITS-TOTAL_BITS){1'b0}}, r_total}
                  + {{(SUM_BITS-LOAD_BITS){1'b0}}, max_load};
        total_acc = (|total_sum[SUM_BITS-1:TOTAL_BITS]) ? '1 : total_sum[TOTAL_BITS-1:0];

        n_load  = upd_load;
        n_total = r_total;
        n_rot   = (placed && i_cfg.mode == acd_pkg::MODE_RR) ? acd_pkg::next_core(rr_core)
                                                             : r_rot;
        if (i_item.last) begin
            n_total = total_acc;
            n_rot   = acd_pkg::CORE0;
            for (int i = 0; i < 3; i++) begin
                n_load[i] = '0;
            end
        end

        btime_ext = {16'd0, (i_item.last ? max_load : {LOAD_BITS{1'b0}})};

        o_result.placed      = placed;
        o_result.chosen_core = core;
        o_result.task_cost   = cost;
        o_result.batch_done  = i_item.last;

        if (i_item.cmd == acd_pkg::CMD_CLEAR) begin
            n_total = '0;
            n_rot   = acd_pkg::CORE0;
            for (int i = 0; i < 3; i++) begin
                n_load[i] = '0;
            end
            o_result.placed      = 1'b0;
            o_result.chosen_core = acd_pkg::CORE0;
            o_result.task_cost   = acd_pkg::COST_NONE;
            o_result.batch_done  = 1'b0;
            btime_ext            = '0;
        end

        total_ext           = {32'd0, n_total};
        o_result.batch_time = btime_ext[15:0];
        o_result.run_total  = total_ext[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            r_rot   <= acd_pkg::CORE0;
            for (int i = 0; i < 3; i++) begin
                r_load[i] <= '0;
            end
        end else if (i_fire) begin
            r_total <= n_total;
            r_rot   <= n_rot;
            r_load  <= n_load;
        end
    end

    // batch close or clear leaves every load empty
    a_batch_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && (i_item.last || i_item.cmd == acd_pkg::CMD_CLEAR)
        |=> r_load[0] == '0 && r_load[1] == '0 && r_load[2] == '0 && r_rot == acd_pkg::CORE0)
        else $error("loads not cleared after batch close");

    a_total_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_item.cmd == acd_pkg::CMD_DISPATCH |=> r_total >= $past(r_total))
        else $error("run total decreased without clear");

    // a placed task always carries a cost, a dropped one never does
    a_cost_placed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_item.cmd == acd_pkg::CMD_DISPATCH
        |-> (o_result.task_cost != acd_pkg::COST_NONE) == o_result.placed)
        else $error("task cost disagrees with placement");

endmodule

/* design/affinity_core_dispatcher.sv */
// Affinity core dispatcher: places typed tasks on three cores and tracks
// each core's load (cost 1 on the core whose home type matches, 2 elsewhere).
// Greedy mode prefers the home core, else the less loaded of the next two in
// rotation, and drops a task with no home; round-robin mode takes cores in
// turn. A task with last_in_batch set adds the largest load to a saturating
// run total and clears the loads; cmd=1 clears everything. One task is
// accepted per clock unless o_stall is raised; its result is offered from the
// result register after passing the input register, and the engine updates
// its loads and total as each task leaves the input register. A transfer
// waiting at the output does not block intake until the input register is
// also full. Configuration lives on an APB port: mode at 0x0, home types of
// cores 0..2 at 0x4, 0x8, 0xC; write it only while no task is in flight.
module affinity_core_dispatcher #(
    parameter int LOAD_BITS  = acd_pkg::LOAD_BITS_DEFAULT,
    parameter int TOTAL_BITS = acd_pkg::TOTAL_BITS_DEFAULT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // APB configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [acd_pkg::ADDR_BITS-1:0] paddr,
    input  logic [acd_pkg::DATA_BITS-1:0] pwdata,
    output logic [acd_pkg::DATA_BITS-1:0] prdata,
    output logic                          pready,
    // task input
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_cmd,
    input  logic [7:0]                    i_task_type,
    input  logic                          i_last_in_batch,
    // result output
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_placed,
    output logic [1:0]                    o_chosen_core,
    output logic [1:0]                    o_task_cost,
    output logic                          o_batch_done,
    output logic [15:0]                   o_batch_time,
    output logic [31:0]                   o_run_total
);

    acd_pkg::t_cfg    r_cfg;
    acd_pkg::t_item   r_item;
    logic             r_in_valid;
    logic             r_out_valid;
    acd_pkg::t_result r_result;
    acd_pkg::t_result eng_result;

    acd_pkg::t_reg_idx reg_idx;
    logic              cfg_wr;
    logic              advance;
    logic              fire;
    logic              in_load;

    // ---------------- configuration registers ----------------
    assign pready  = 1'b1;
    assign reg_idx = paddr[acd_pkg::ADDR_BITS-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode         <= acd_pkg::MODE_GREEDY;
            r_cfg.home_type[0] <= acd_pkg::HOME0_RESET;
            r_cfg.home_type[1] <= acd_pkg::HOME1_RESET;
            r_cfg.home_type[2] <= acd_pkg::HOME2_RESET;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                acd_pkg::REG_MODE:  r_cfg.mode         <= pwdata[0];
                acd_pkg::REG_HOME0: r_cfg.home_type[0] <= pwdata[7:0];
                acd_pkg::REG_HOME1: r_cfg.home_type[1] <= pwdata[7:0];
                acd_pkg::REG_HOME2: r_cfg.home_type[2] <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            acd_pkg::REG_MODE:  prdata = {31'd0, r_cfg.mode};
            acd_pkg::REG_HOME0: prdata = {24'd0, r_cfg.home_type[0]};
            acd_pkg::REG_HOME1: prdata = {24'd0, r_cfg.home_type[1]};
            acd_pkg::REG_HOME2: prdata = {24'd0, r_cfg.home_type[2]};
            default:            prdata = '0;
        endcase
    end

    // ---------------- pipeline control ----------------
    // result register frees when empty or taken this cycle
    assign advance = !r_out_valid || !i_stall;
    // input register is full and cannot drain into the result register
    assign o_stall = r_in_valid && !advance;
    assign in_load = advance || !r_in_valid;
    assign fire    = r_in_valid && advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_load) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_item.cmd       <= i_cmd;
            r_item.task_type <= i_task_type;
            r_item.last      <= i_last_in_batch;
        end
    end

    acd_engine #(
        .LOAD_BITS  (LOAD_BITS),
        .TOTAL_BITS (TOTAL_BITS)
    ) u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_item),
        .i_cfg    (r_cfg),
        .o_result (eng_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_result <= eng_result;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_placed      = r_result.placed;
    assign o_chosen_core = r_result.chosen_core;
    assign o_task_cost   = r_result.task_cost;
    assign o_batch_done  = r_result.batch_done;
    assign o_batch_time  = r_result.batch_time;
    assign o_run_total   = r_result.run_total;

    // ---------------- checks ----------------
    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_in_valid && r_out_valid && i_stall)
        else $error("input stalled with room in the pipeline");

    a_fire_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> o_valid)
        else $error("processed task produced no result");

    a_skid_absorbs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !r_in_valid && r_out_valid && i_stall |=> r_in_valid)
        else $error("transfer lost while output stalled");

    a_unplaced_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && !eng_result.placed |=> o_chosen_core == acd_pkg::CORE0
                                      && o_task_cost == acd_pkg::COST_NONE)
        else $error("dropped task carries a core or cost");

endmodule

/* tb/affinity_core_dispatcher_test.sv */
`timescale 1ns / 1ps

// Dispatcher testbench: a directed table first, then random phases under
// random register settings. Every accepted task runs through a local
// placement predictor, and each result transfer is checked field by field
// against the oldest pending prediction.
module affinity_core_dispatcher_test;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 11;
    localparam int PIPE_DEPTH     = 2;              // input reg + result reg
    localparam int SETTLE_CYCLES  = 4 * PIPE_DEPTH;
    localparam int HOLD_CYCLES    = 80;             // long receiver hold-off
    localparam int IDLE_PCT       = 22;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASES         = 12;
    localparam int PHASE_ITEMS    = 152;
    localparam int LOAD_W         = acd_pkg::LOAD_BITS_DEFAULT;
    localparam int TOTAL_W        = acd_pkg::TOTAL_BITS_DEFAULT;

    localparam logic [LOAD_W-1:0]  LOAD_MAX  = '1;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    typedef enum logic {ROW_TASK, ROW_REG} t_row_kind;

    // One row of the directed table: a task transfer or a register write.
    // typed rows carry a hand-written result that replaces the prediction.
    typedef struct packed {
        t_row_kind         kind;
        acd_pkg::t_reg_idx reg_idx;
        logic [7:0]        reg_val;
        acd_pkg::t_item    item;
        logic              typed;
        acd_pkg::t_result  golden;
    } t_row;

    logic                          i_clk           = 1'b0;
    logic                          i_rst_n         = 1'b0;
    logic                          psel            = 1'b0;
    logic                          penable         = 1'b0;
    logic                          pwrite          = 1'b0;
    logic [acd_pkg::ADDR_BITS-1:0] paddr           = '0;
    logic [acd_pkg::DATA_BITS-1:0] pwdata          = '0;
    logic [acd_pkg::DATA_BITS-1:0] prdata;
    logic                          pready;
    logic                          i_valid         = 1'b0;
    logic                          o_stall;
    logic                          i_cmd           = acd_pkg::CMD_DISPATCH;
    logic [7:0]                    i_task_type     = '0;
    logic                          i_last_in_batch = 1'b0;
    logic                          o_valid;
    logic                          i_stall         = 1'b0;
    logic                          o_placed;
    logic [1:0]                    o_chosen_core;
    logic [1:0]                    o_task_cost;
    logic                          o_batch_done;
    logic [15:0]                   o_batch_time;
    logic [31:0]                   o_run_total;

    // predictor copy of configuration and state
    logic               cfg_mode;
    logic [7:0]         cfg_home [3];
    logic [LOAD_W-1:0]  core_load_q [3];
    logic [TOTAL_W-1:0] run_time_q;
    acd_pkg::t_core     rot_q;

    acd_pkg::t_result expected_results [$];
    t_row             directed_plan [$];
    int               err_cnt     = 0;
    int               idle_cycles = 0;
    logic             calm        = 1'b0;    // no idling on either side
    logic             hold_req    = 1'b0;    // ask the receiver for a long hold-off

    affinity_core_dispatcher u_top (.*);

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic acd_pkg::t_core following_core(input acd_pkg::t_core c);
        return (c == acd_pkg::CORE2) ? acd_pkg::CORE0 : acd_pkg::t_core'(c + 2'd1);
    endfunction

    function automatic void empty_cores();
        foreach (core_load_q[c])
            core_load_q[c] = '0;
        rot_q = acd_pkg::CORE0;
    endfunction

    function automatic void add_row(input t_row r);
        directed_plan.insert(directed_plan.size(), r);
    endfunction

    // Placement of one task plus the batch bookkeeping it causes.
    function automatic acd_pkg::t_result place_task(input logic cmd, input logic [7:0] ttype,
                                                    input logic last);
        acd_pkg::t_result  r;
        acd_pkg::t_core    home, n1, n2, pick;
        logic              found;
        logic [LOAD_W:0]   lh, l1, l2, sum;
        logic [LOAD_W-1:0] peak;
        r     = '0;
        found = 1'b0;
        home  = acd_pkg::CORE0;
        pick  = acd_pkg::CORE0;
        if (cmd == acd_pkg::CMD_CLEAR) begin
            run_time_q = '0;
            empty_cores();
            return r;
        end
        if (cfg_mode == acd_pkg::MODE_RR) begin
            pick     = (rot_q > acd_pkg::CORE2) ? acd_pkg::CORE0 : rot_q;
            rot_q    = following_core(pick);
            r.placed = 1'b1;
        end else begin
            // lowest index wins when home types repeat
            for (int h = 2; h >= 0; h--) begin
                if (cfg_home[h] == ttype) begin
                    found = 1'b1;
                    home  = acd_pkg::t_core'(h);
                end
            end
            if (found) begin
                n1 = following_core(home);
                n2 = following_core(n1);
                lh = core_load_q[home] + 1'b1;
                l1 = core_load_q[n1] + 2'd2;
                l2 = core_load_q[n2] + 2'd2;
                if (lh <= l1 && lh <= l2)
                    pick = home;
                else if (l1 <= l2)
                    pick = n1;
                else
                    pick = n2;
                r.placed = 1'b1;
            end
        end
        if (r.placed) begin
            r.chosen_core     = pick;
            r.task_cost       = (cfg_home[pick] == ttype) ? acd_pkg::COST_HOME
                                                          : acd_pkg::COST_AWAY;
            sum               = core_load_q[pick] + r.task_cost;
            core_load_q[pick] = sum[LOAD_W] ? LOAD_MAX : sum[LOAD_W-1:0];
        end
        if (last) begin
            peak = core_load_q[0];
            if (core_load_q[1] > peak) peak = core_load_q[1];
            if (core_load_q[2] > peak) peak = core_load_q[2];
            if (TOTAL_MAX - run_time_q < TOTAL_W'(peak))
                run_time_q = TOTAL_MAX;
            else
                run_time_q = run_time_q + TOTAL_W'(peak);
            r.batch_done = 1'b1;
            r.batch_time = 16'(peak);
            empty_cores();
        end
        r.run_total = run_time_q[31:0];
        return r;
    endfunction

    function automatic t_row task_row(input logic cmd, input logic [7:0] ttype,
                                      input logic last);
        t_row r;
        r = '0;
        r.kind                = ROW_TASK;
        r.item.cmd            = cmd;
        r.item.task_type      = ttype;
        r.item.last           = last;
        return r;
    endfunction

    function automatic t_row typed_row(input logic cmd, input logic [7:0] ttype,
                                       input logic last, input acd_pkg::t_result golden);
        t_row r;
        r        = task_row(cmd, ttype, last);
        r.typed  = 1'b1;
        r.golden = golden;
        return r;
    endfunction

    function automatic t_row reg_row(input acd_pkg::t_reg_idx idx, input logic [7:0] val);
        t_row r;
        r = '0;
        r.kind    = ROW_REG;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    // APB write: setup phase, then access phase, then idle with psel low
    task automatic write_reg(input acd_pkg::t_reg_idx idx, input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= acd_pkg::DATA_BITS'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        case (idx)
            acd_pkg::REG_MODE:  cfg_mode    = value[0];
            acd_pkg::REG_HOME0: cfg_home[0] = value;
            acd_pkg::REG_HOME1: cfg_home[1] = value;
            acd_pkg::REG_HOME2: cfg_home[2] = value;
            default: ;
        endcase
    endtask

    // stop sending and wait until every predicted result has come back
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_task(input logic cmd, input logic [7:0] ttype, input logic last,
                             input logic typed, input acd_pkg::t_result golden);
        acd_pkg::t_result res;
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_cmd           <= cmd;
        i_task_type     <= ttype;
        i_last_in_batch <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        res = place_task(cmd, ttype, last);
        expected_results.insert(expected_results.size(), typed ? golden : res);
    endtask

    initial begin : stimulus
        logic [7:0] v;
        logic [7:0] ttype;
        logic       cmd;
        logic       last;
        t_row       row;

        cfg_mode    = acd_pkg::MODE_GREEDY;
        cfg_home[0] = acd_pkg::HOME0_RESET;
        cfg_home[1] = acd_pkg::HOME1_RESET;
        cfg_home[2] = acd_pkg::HOME2_RESET;
        run_time_q  = '0;
        empty_cores();

        // reset homes: 'H' on core 0, 'M' on core 1, 'L' on core 2
        add_row(typed_row(acd_pkg::CMD_CLEAR, 8'hFF, 1'b1, '0));
        // no home: dropped, but last still closes an empty batch
        add_row(typed_row(acd_pkg::CMD_DISPATCH, 8'h00, 1'b1,
            '{placed: 1'b0, chosen_core: acd_pkg::CORE0, task_cost: acd_pkg::COST_NONE,
              batch_done: 1'b1, batch_time: 16'd0, run_total: 32'd0}));
        add_row(typed_row(acd_pkg::CMD_DISPATCH, 8'd72, 1'b0,
            '{placed: 1'b1, chosen_core: acd_pkg::CORE0, task_cost: acd_pkg::COST_HOME,
              batch_done: 1'b0, batch_time: 16'd0, run_total: 32'd0}));
        // home core fills up, then spills over at cost two
        add_row(task_row(acd_pkg::CMD_DISPATCH, 8'd72, 1'b0));
        add_row(task_row(acd_pkg::CMD_DISPATCH, 8'd72, 1'b0));
        add_row(task_row(acd_pkg::CMD_DISPATCH, 8'd72, 1'b0));
        add_row(task_row(acd_pkg::CMD_DISPATCH, 8'd77, 1'b0));
        add_row(task_row(acd_pkg::CMD_DISPATCH, 8'd76, 1'b0));
        add_row(task_row(acd_pkg::CMD_DISPATCH, 8'hFF, 1'b0));
        add_row(task_row(acd_pkg::CMD_DISPATCH, 8'd76, 1'b1));
        add_row(typed_row(acd_pkg::CMD_CLEAR, 8'h00, 1'b0, '0));
        // repeated home types: core 0 is home, core 1 still charges one
        add_row(reg_row(acd_pkg::REG_HOME0, 8'h55));
        add_row(reg_row(acd_pkg::REG_HOME1, 8'h55));
        add_row(reg_row(acd_pkg::REG_HOME2, 8'h55));
        add_row(task_row(acd_pkg::CMD_DISPATCH, 8'h55, 1'b0));
        add_row(task_row(acd_pkg::CMD_DISPATCH, 8'h55, 1'b0));
        add_row(task_row(acd_pkg::CMD_DISPATCH, 8'h55, 1'b0));
        add_row(task_row(acd_pkg::CMD_DISPATCH, 8'h55, 1'b1));
        // round robin, rotation restarts after a batch closes
        add_row(reg_row(acd_pkg::REG_MODE, {7'd0, acd_pkg::MODE_RR}));
        add_row(task_row(acd_pkg::CMD_DISPATCH, 8'h55, 1'b0));
        add_row(task_row(acd_pkg::CMD_DISPATCH, 8'hFF, 1'b0));
        add_row(task_row(acd_pkg::CMD_DISPATCH, 8'hAA, 1'b1));
        add_row(task_row(acd_pkg::CMD_DISPATCH, 8'h13, 1'b0));
        // extreme home types
        add_row(reg_row(acd_pkg::REG_HOME0, 8'h00));
        add_row(reg_row(acd_pkg::REG_HOME1, 8'hFF));
        add_row(reg_row(acd_pkg::REG_HOME2, 8'h80));
        add_row(task_row(acd_pkg::CMD_DISPATCH, 8'h00, 1'b0));
        add_row(task_row(acd_pkg::CMD_DISPATCH, 8'hFF, 1'b1));
        add_row(reg_row(acd_pkg::REG_MODE, {7'd0, acd_pkg::MODE_GREEDY}));
        add_row(task_row(acd_pkg::CMD_DISPATCH, 8'h00, 1'b0));
        add_row(task_row(acd_pkg::CMD_DISPATCH, 8'h7F, 1'b0));
        add_row(task_row(acd_pkg::CMD_DISPATCH, 8'hFF, 1'b1));

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_plan[i]) begin
            row = directed_plan[i];
            if (row.kind == ROW_REG) begin
                drain();
                write_reg(row.reg_idx, row.reg_val);
            end else begin
                send_task(row.item.cmd, row.item.task_type, row.item.last,
                          row.typed, row.golden);
            end
        end

        // random phases, each under a fresh register setting
        for (int p = 0; p < PHASES; p++) begin
            drain();
            write_reg(acd_pkg::REG_MODE,
                      {7'd0, (p % 3 == 2) ? acd_pkg::MODE_RR : acd_pkg::MODE_GREEDY});
            for (int c = 0; c < 3; c++) begin
                case ($urandom_range(0, 5))
                    0:       v = 8'h00;
                    1:       v = 8'hFF;
                    2:       v = cfg_home[0];       // duplicate home type
                    default: v = 8'($urandom_range(0, 255));
                endcase
                write_reg(acd_pkg::t_reg_idx'(acd_pkg::REG_HOME0 + c), v);
            end
            calm = (p == 3);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 6 && n == 40)
                    hold_req = 1'b1;
                cmd = ($urandom_range(0, 39) == 0) ? acd_pkg::CMD_CLEAR
                                                   : acd_pkg::CMD_DISPATCH;
                // mostly tasks with a home somewhere, the rest any type
                if ($urandom_range(0, 3) != 0)
                    ttype = cfg_home[$urandom_range(0, 2)];
                else
                    ttype = 8'($urandom_range(0, 255));
                // one phase runs long batches
                last = ($urandom_range(0, (p == 8) ? 59 : 9) == 0);
                send_task(cmd, ttype, last, 1'b0, '0);
            end
        end
        calm = 1'b0;
        drain();

        if (err_cnt == 0)
            $display("** affinity_core_dispatcher: PASSED **");
        else
            $display("** affinity_core_dispatcher: FAILED **");
        $finish;
    end

    // receiver: random stall, plus one long hold-off on request
    initial begin : result_sink
        logic hold_done;
        hold_done = 1'b0;
        forever begin
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                i_stall <= (!calm && $urandom_range(99) < IDLE_PCT);
                @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        acd_pkg::t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                $error("result transfer with nothing pending");
                err_cnt++;
            end else begin
                want = expected_results.pop_front();
                if (o_placed !== want.placed) begin
                    $error("placed: expected %0d, got %0d", want.placed, o_placed);
                    err_cnt++;
                end
                if (o_chosen_core !== want.chosen_core) begin
                    $error("chosen_core: expected %0d, got %0d",
                           want.chosen_core, o_chosen_core);
                    err_cnt++;
                end
                if (o_task_cost !== want.task_cost) begin
                    $error("task_cost: expected %0d, got %0d", want.task_cost, o_task_cost);
                    err_cnt++;
                end
                if (o_batch_done !== want.batch_done) begin
                    $error("batch_done: expected %0d, got %0d",
                           want.batch_done, o_batch_done);
                    err_cnt++;
                end
                if (o_batch_time !== want.batch_time) begin
                    $error("batch_time: expected %0d, got %0d",
                           want.batch_time, o_batch_time);
                    err_cnt++;
                end
                if (o_run_total !== want.run_total) begin
                    $error("run_total: expected %0d, got %0d", want.run_total, o_run_total);
                    err_cnt++;
                end
            end
        end
    end

    // watchdog: cycles without any transfer on either channel or the APB port
    always @(posedge i_clk) begin
        if (!i_rst_n || (psel && penable && pready) || (i_valid && !o_stall)
                || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("** affinity_core_dispatcher: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
